// File: src/qsa_pkg.sv
// ----------------------------------------------------------------------------
// qsa_pkg
// Types and constants shared by the queue statistics accumulator modules.
// ----------------------------------------------------------------------------
package qsa_pkg;

    localparam int TIME_W   = 24;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 64;
    localparam int MEAN_W   = 32;
    localparam int VAR_W    = 56;
    localparam int RATIO_W  = 17;
    localparam int DIV_DW   = 72;
    localparam int DIV_VW   = 24;
    localparam int DIV_CW   = 7;
    localparam int PROD_W   = 64;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

    typedef enum logic [1:0] {
        FUNC_ACCEPT = 2'd0,
        FUNC_REJECT = 2'd1,
        FUNC_REPORT = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        DS_MW  = 3'd0,
        DS_MS  = 3'd1,
        DS_QW  = 3'd2,
        DS_QS  = 3'd3,
        DS_RAT = 3'd4,
        DS_SRV = 3'd5
    } t_div_sel;

    typedef enum logic [1:0] {
        MUL_W  = 2'd0,
        MUL_P  = 2'd1,
        MUL_MW = 2'd2,
        MUL_MS = 2'd3
    } t_mul_sel;

    typedef struct packed {
        logic [1:0]        func;
        logic [2:0]        client;
        logic [2:0]        server;
        logic [TIME_W-1:0] time_enter;
        logic [TIME_W-1:0] time_start;
        logic [TIME_W-1:0] time_finish;
    } t_in_item;

    typedef struct packed {
        logic               is_server;
        logic [2:0]         index;
        logic [CNT_W-1:0]   accepted_count;
        logic [CNT_W-1:0]   rejected_count;
        logic [CNT_W:0]     total_count;
        logic [MEAN_W-1:0]  mean_wait;
        logic [MEAN_W-1:0]  mean_service;
        logic [MEAN_W:0]    mean_residence;
        logic [VAR_W-1:0]   var_wait;
        logic [VAR_W-1:0]   var_service;
        logic [RATIO_W-1:0] ratio;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic     load_item;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     wsq_upd;
        logic     rec_upd;
        logic     rej_upd;
        logic     idx_clr;
        logic     idx_inc;
        logic     div_start;
        t_div_sel div_sel;
        logic     var_w;
        logic     var_s;
        logic     out_client;
        logic     out_server;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  rec_ok;
        logic  rej_ok;
        logic  div_done;
        logic  out_free;
        logic  idx_last_client;
        logic  idx_last_server;
    } t_dp_stat;

endpackage

// File: src/qsa_div.sv
// ----------------------------------------------------------------------------
// qsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qsa_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [qsa_pkg::DIV_DW-1:0] i_dividend,
    input  logic [qsa_pkg::DIV_VW-1:0] i_divisor,
    output logic [qsa_pkg::DIV_DW-1:0] o_quotient,
    output logic                      o_done
);
    import qsa_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_VW-1:0] r_rem;
    logic [DIV_VW-1:0] r_dvs;
    logic [DIV_DW-1:0] r_quo;
    logic [DIV_VW:0]   trial;
    logic [DIV_VW:0]   diff;
    logic              ge;

    assign trial = {r_rem, r_quo[DIV_DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_VW-1:0] : trial[DIV_VW-1:0];
            r_quo <= {r_quo[DIV_DW-2:0], ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: src/qsa_datapath.sv
// ----------------------------------------------------------------------------
// qsa_datapath
// Per-client and per-server sums, shared multiplier and divider, output item.
// ----------------------------------------------------------------------------
module qsa_datapath #(
    parameter int CLIENTS = 8,
    parameter int SERVERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qsa_pkg::t_in_item  i_in_item,
    input  qsa_pkg::t_dp_cmd   i_cmd,
    output qsa_pkg::t_dp_stat  o_stat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output qsa_pkg::t_out_item o_out_item
);
    import qsa_pkg::*;

    localparam int CW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int SW   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
    localparam int MAXN = (CLIENTS > SERVERS) ? CLIENTS : SERVERS;
    localparam int IW   = (MAXN > 1) ? $clog2(MAXN) : 1;

    logic [CNT_W-1:0]  r_acc   [CLIENTS];
    logic [CNT_W-1:0]  r_rej   [CLIENTS];
    logic [SUM_W-1:0]  r_wsum  [CLIENTS];
    logic [SUM_W-1:0]  r_ssum  [CLIENTS];
    logic [SQ_W-1:0]   r_wsq   [CLIENTS];
    logic [SQ_W-1:0]   r_ssq   [CLIENTS];
    logic [SUM_W-1:0]  r_busy  [SERVERS];
    logic [TIME_W-1:0] r_lastf [SERVERS];

    t_in_item           r_in;
    logic [TIME_W-1:0]  r_w;
    logic [TIME_W-1:0]  r_p;
    logic [PROD_W-1:0]  r_prod;
    logic [IW-1:0]      r_idx;
    logic [MEAN_W-1:0]  r_mw;
    logic [MEAN_W-1:0]  r_ms;
    logic [VAR_W-1:0]   r_qw;
    logic [VAR_W-1:0]   r_qs;
    logic [VAR_W-1:0]   r_vw;
    logic [VAR_W-1:0]   r_vs;
    logic [RATIO_W-1:0] r_rat;
    logic               r_ovalid;
    t_out_item          r_out;

    logic [CW-1:0]      rc;
    logic [SW-1:0]      rs;
    logic [CW-1:0]      ic;
    logic [SW-1:0]      is;
    logic [MEAN_W-1:0]  mul_a;
    logic [SUM_W:0]     wsum_n;
    logic [SUM_W:0]     ssum_n;
    logic [SUM_W:0]     busy_n;
    logic [SQ_W:0]      wsq_n;
    logic [SQ_W:0]      ssq_n;
    logic [DIV_DW-1:0]  dvd;
    logic [DIV_VW-1:0]  dvs;
    logic [DIV_DW-1:0]  quo;
    logic               div_done;
    logic               div_zero;
    logic [CNT_W:0]     tot;
    logic [VAR_W-1:0]   sq_sh;
    logic               out_free;

    assign rc = CW'(r_in.client);
    assign rs = SW'(r_in.server);
    assign ic = r_idx[CW-1:0];
    assign is = r_idx[SW-1:0];
    assign tot = {1'b0, r_acc[ic]} + {1'b0, r_rej[ic]};
    assign out_free = !r_ovalid || !i_out_stall;

    // status
    always_comb begin
        o_stat.func            = t_func'(r_in.func);
        o_stat.rec_ok          = (int'(r_in.client) < CLIENTS) && (int'(r_in.server) < SERVERS);
        o_stat.rej_ok          = int'(r_in.client) < CLIENTS;
        o_stat.div_done        = div_done;
        o_stat.out_free        = out_free;
        o_stat.idx_last_client = r_idx == IW'(CLIENTS - 1);
        o_stat.idx_last_server = r_idx == IW'(SERVERS - 1);
    end

    // saturating sums
    assign wsum_n = {1'b0, r_wsum[rc]} + (SUM_W + 1)'(r_w);
    assign ssum_n = {1'b0, r_ssum[rc]} + (SUM_W + 1)'(r_p);
    assign busy_n = {1'b0, r_busy[rs]} + (SUM_W + 1)'(r_p);
    assign wsq_n  = {1'b0, r_wsq[rc]} + {1'b0, r_prod};
    assign ssq_n  = {1'b0, r_ssq[rc]} + {1'b0, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CLIENTS; k++) begin
                r_acc[k]  <= '0;
                r_rej[k]  <= '0;
                r_wsum[k] <= '0;
                r_ssum[k] <= '0;
                r_wsq[k]  <= '0;
                r_ssq[k]  <= '0;
            end
            for (int k = 0; k < SERVERS; k++) begin
                r_busy[k]  <= '0;
                r_lastf[k] <= '0;
            end
        end else begin
            if (i_cmd.wsq_upd) begin
                r_wsq[rc] <= wsq_n[SQ_W] ? '1 : wsq_n[SQ_W-1:0];
            end
            if (i_cmd.rec_upd) begin
                r_ssq[rc]  <= ssq_n[SQ_W] ? '1 : ssq_n[SQ_W-1:0];
                r_wsum[rc] <= wsum_n[SUM_W] ? '1 : wsum_n[SUM_W-1:0];
                r_ssum[rc] <= ssum_n[SUM_W] ? '1 : ssum_n[SUM_W-1:0];
                r_busy[rs] <= busy_n[SUM_W] ? '1 : busy_n[SUM_W-1:0];
                r_lastf[rs] <= r_in.time_finish;
                if (r_acc[rc] != '1) begin
                    r_acc[rc] <= r_acc[rc] + 1'b1;
                end
            end
            if (i_cmd.rej_upd && r_rej[rc] != '1) begin
                r_rej[rc] <= r_rej[rc] + 1'b1;
            end
        end
    end

    // item capture and multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_W:   mul_a = MEAN_W'(r_w);
            MUL_P:   mul_a = MEAN_W'(r_p);
            MUL_MW:  mul_a = r_mw;
            MUL_MS:  mul_a = r_ms;
            default: mul_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_in <= i_in_item;
            r_w  <= (i_in_item.time_start > i_in_item.time_enter)
                    ? i_in_item.time_start - i_in_item.time_enter : '0;
            r_p  <= (i_in_item.time_finish > i_in_item.time_start)
                    ? i_in_item.time_finish - i_in_item.time_start : '0;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // divider operands
    always_comb begin
        dvd      = '0;
        dvs      = '0;
        div_zero = 1'b0;
        case (i_cmd.div_sel)
            DS_MW: begin
                dvd      = DIV_DW'({r_wsum[ic], 8'b0});
                dvs      = DIV_VW'(r_acc[ic]);
                div_zero = r_acc[ic] == '0;
            end
            DS_MS: begin
                dvd      = DIV_DW'({r_ssum[ic], 8'b0});
                dvs      = DIV_VW'(r_acc[ic]);
                div_zero = r_acc[ic] == '0;
            end
            DS_QW: begin
                dvd      = {r_wsq[ic], 8'b0};
                dvs      = DIV_VW'(r_acc[ic]);
                div_zero = r_acc[ic] == '0;
            end
            DS_QS: begin
                dvd      = {r_ssq[ic], 8'b0};
                dvs      = DIV_VW'(r_acc[ic]);
                div_zero = r_acc[ic] == '0;
            end
            DS_RAT: begin
                dvd      = DIV_DW'({r_rej[ic], 16'b0});
                dvs      = DIV_VW'(tot);
                div_zero = tot == '0;
            end
            DS_SRV: begin
                dvd      = DIV_DW'({r_busy[is], 16'b0});
                dvs      = r_lastf[is];
                div_zero = r_lastf[is] == '0;
            end
            default: begin
                div_zero = 1'b1;
            end
        endcase
    end

    qsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    assign sq_sh = r_prod[PROD_W-1:8];

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (i_cmd.div_sel)
                DS_MW: r_mw <= div_zero ? '0 :
                               (quo[DIV_DW-1:MEAN_W] != '0) ? '1 : quo[MEAN_W-1:0];
                DS_MS: r_ms <= div_zero ? '0 :
                               (quo[DIV_DW-1:MEAN_W] != '0) ? '1 : quo[MEAN_W-1:0];
                DS_QW: r_qw <= div_zero ? '0 :
                               (quo[DIV_DW-1:VAR_W] != '0) ? '1 : quo[VAR_W-1:0];
                DS_QS: r_qs <= div_zero ? '0 :
                               (quo[DIV_DW-1:VAR_W] != '0) ? '1 : quo[VAR_W-1:0];
                DS_RAT: r_rat <= div_zero ? '0 : quo[RATIO_W-1:0];
                DS_SRV: r_rat <= div_zero ? '0 :
                                 (quo > DIV_DW'(RATIO_ONE)) ? RATIO_ONE : quo[RATIO_W-1:0];
                default: r_rat <= r_rat;
            endcase
        end
        if (i_cmd.var_w) begin
            r_vw <= (r_qw > sq_sh) ? r_qw - sq_sh : '0;
        end
        if (i_cmd.var_s) begin
            r_vs <= (r_qs > sq_sh) ? r_qs - sq_sh : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_client || i_cmd.out_server) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_client) begin
            r_out.is_server      <= 1'b0;
            r_out.index          <= 3'(r_idx);
            r_out.accepted_count <= r_acc[ic];
            r_out.rejected_count <= r_rej[ic];
            r_out.total_count    <= tot;
            r_out.mean_wait      <= r_mw;
            r_out.mean_service   <= r_ms;
            r_out.mean_residence <= {1'b0, r_mw} + {1'b0, r_ms};
            r_out.var_wait       <= r_vw;
            r_out.var_service    <= r_vs;
            r_out.ratio          <= r_rat;
            r_out.last           <= 1'b0;
        end else if (i_cmd.out_server) begin
            r_out                <= '0;
            r_out.is_server      <= 1'b1;
            r_out.index          <= 3'(r_idx);
            r_out.ratio          <= r_rat;
            r_out.last           <= r_idx == IW'(SERVERS - 1);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

endmodule

// File: src/qsa_ctrl.sv
// ----------------------------------------------------------------------------
// qsa_ctrl
// Sequencer for record updates and report generation.
// ----------------------------------------------------------------------------
module qsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  qsa_pkg::t_dp_stat i_stat,
    output qsa_pkg::t_dp_cmd  o_cmd
);
    import qsa_pkg::*;

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_DEC     = 15'b000000000000010,
        ST_REC_W   = 15'b000000000000100,
        ST_REC_P   = 15'b000000000001000,
        ST_REC_UPD = 15'b000000000010000,
        ST_REJ     = 15'b000000000100000,
        ST_C_DIV   = 15'b000000001000000,
        ST_C_WAIT  = 15'b000000010000000,
        ST_C_MUL   = 15'b000000100000000,
        ST_C_VARW  = 15'b000001000000000,
        ST_C_VARS  = 15'b000010000000000,
        ST_C_OUT   = 15'b000100000000000,
        ST_S_DIV   = 15'b001000000000000,
        ST_S_WAIT  = 15'b010000000000000,
        ST_S_OUT   = 15'b100000000000000
    } t_state;

    t_state   r_state, n_state;
    t_div_sel r_step, n_step;
    t_div_sel step_next;

    always_comb begin
        case (r_step)
            DS_MW:   step_next = DS_MS;
            DS_MS:   step_next = DS_QW;
            DS_QW:   step_next = DS_QS;
            DS_QS:   step_next = DS_RAT;
            default: step_next = DS_MW;
        endcase
    end

    assign o_in_stall = r_state != ST_IDLE;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.div_sel = r_step;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = ST_DEC;
                end
            end
            ST_DEC: begin
                case (i_stat.func)
                    FUNC_ACCEPT: n_state = i_stat.rec_ok ? ST_REC_W : ST_IDLE;
                    FUNC_REJECT: n_state = i_stat.rej_ok ? ST_REJ : ST_IDLE;
                    FUNC_REPORT: begin
                        o_cmd.idx_clr = 1'b1;
                        n_step  = DS_MW;
                        n_state = ST_C_DIV;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_REC_W: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_W;
                n_state = ST_REC_P;
            end
            ST_REC_P: begin
                o_cmd.wsq_upd = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
                n_state = ST_REC_UPD;
            end
            ST_REC_UPD: begin
                o_cmd.rec_upd = 1'b1;
                n_state = ST_IDLE;
            end
            ST_REJ: begin
                o_cmd.rej_upd = 1'b1;
                n_state = ST_IDLE;
            end
            ST_C_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_C_WAIT;
            end
            ST_C_WAIT: begin
                if (i_stat.div_done) begin
                    if (r_step == DS_RAT) begin
                        n_state = ST_C_MUL;
                    end else begin
                        n_step  = step_next;
                        n_state = ST_C_DIV;
                    end
                end
            end
            ST_C_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MW;
                n_state = ST_C_VARW;
            end
            ST_C_VARW: begin
                o_cmd.var_w   = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_MS;
                n_state = ST_C_VARS;
            end
            ST_C_VARS: begin
                o_cmd.var_s = 1'b1;
                n_state = ST_C_OUT;
            end
            ST_C_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_client = 1'b1;
                    if (i_stat.idx_last_client) begin
                        o_cmd.idx_clr = 1'b1;
                        n_step  = DS_SRV;
                        n_state = ST_S_DIV;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_step  = DS_MW;
                        n_state = ST_C_DIV;
                    end
                end
            end
            ST_S_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_S_WAIT;
            end
            ST_S_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = ST_S_OUT;
                end
            end
            ST_S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_server = 1'b1;
                    if (i_stat.idx_last_server) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = ST_S_DIV;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= DS_MW;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: src/queue_stats_accumulator.sv
// ----------------------------------------------------------------------------
// queue_stats_accumulator
// Per-client and per-server queue service statistics with report output.
// ----------------------------------------------------------------------------
// an accepted record passes decode, two multiply states and an update; a rejected
// record passes decode and a reject update; other codes end after decode; a report
// uses the shared 72-step restoring divider per statistic and waits on output stalls
// one item is worked on at a time; input is stalled until it is finished
// synchronous active-low reset clears all counts, sums and last finish times
module queue_stats_accumulator #(
    parameter int CLIENTS = 8,
    parameter int SERVERS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qsa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qsa_pkg::t_out_item o_out_item
);
    import qsa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    qsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    qsa_datapath #(
        .CLIENTS (CLIENTS),
        .SERVERS (SERVERS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: dv/queue_stats_accumulator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queue_stats_accumulator_test
// Self-checking bench for the queue statistics accumulator. Records and
// reports are driven through the valid/stall input channel; a scoreboard
// keeps its own per-client and per-server sums, predicts every report item
// and compares each output item field by field with random idling on both
// sides, plus one long output hold-off.
// ----------------------------------------------------------------------------
module queue_stats_accumulator_test;
    import qsa_pkg::*;

    localparam int NCLI = 8;
    localparam int NSRV = 8;
    localparam logic [63:0] MAX16 = 64'hFFFF;
    localparam logic [63:0] MAX32 = 64'hFFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] MAX56 = 64'hFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX64 = '1;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic [63:0] acc_cnt [NCLI];
    logic [63:0] rej_cnt [NCLI];
    logic [63:0] wait_sum [NCLI];
    logic [63:0] svc_sum [NCLI];
    logic [63:0] wait_sq [NCLI];
    logic [63:0] svc_sq [NCLI];
    logic [63:0] busy_sum [NSRV];
    logic [63:0] last_fin [NSRV];

    t_out_item report_q[$];
    int        errors = 0;
    int        idle_pct = 27;
    bit        pressure_req = 1'b0;
    int        hold_cnt = 0;
    logic [23:0] tick = 24'd0;

    queue_stats_accumulator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, lim}) ? lim : s[63:0];
    endfunction

    function automatic logic [63:0] mean_q8(logic [63:0] sum, logic [63:0] n);
        logic [127:0] m;
        if (n == 0) return 0;
        m = ({64'd0, sum} << 8) / n;
        return (m > MAX32) ? MAX32 : m[63:0];
    endfunction

    function automatic logic [63:0] var_q8(logic [63:0] sq, logic [63:0] n, logic [63:0] mean);
        logic [127:0] q, r, msq, m2;
        if (n == 0) return 0;
        q = sq / n;
        r = sq % n;
        if (q >= (128'd1 << 48)) msq = MAX56;
        else msq = (q << 8) + ((r << 8) / n);
        m2 = ({64'd0, mean} * mean) >> 8;
        return (msq > m2) ? (msq - m2) : 0;
    endfunction

    task automatic clear_stats();
        for (int i = 0; i < NCLI; i++) begin
            acc_cnt[i] = 0; rej_cnt[i] = 0; wait_sum[i] = 0;
            svc_sum[i] = 0; wait_sq[i] = 0; svc_sq[i] = 0;
        end
        for (int i = 0; i < NSRV; i++) begin
            busy_sum[i] = 0; last_fin[i] = 0;
        end
    endtask

    task automatic predict_report(t_in_item it);
        logic [63:0] w, p, n, r, mw, ms, d;
        logic [127:0] rt;
        t_out_item o;
        case (it.func)
            FUNC_ACCEPT: begin
                w = (it.time_start > it.time_enter) ? it.time_start - it.time_enter : 0;
                p = (it.time_finish > it.time_start) ? it.time_finish - it.time_start : 0;
                acc_cnt[it.client] = sat_add(acc_cnt[it.client], 1, MAX16);
                wait_sum[it.client] = sat_add(wait_sum[it.client], w, MAX40);
                svc_sum[it.client] = sat_add(svc_sum[it.client], p, MAX40);
                wait_sq[it.client] = sat_add(wait_sq[it.client], w * w, MAX64);
                svc_sq[it.client] = sat_add(svc_sq[it.client], p * p, MAX64);
                busy_sum[it.server] = sat_add(busy_sum[it.server], p, MAX40);
                last_fin[it.server] = it.time_finish;
            end
            FUNC_REJECT: rej_cnt[it.client] = sat_add(rej_cnt[it.client], 1, MAX16);
            FUNC_REPORT: begin
                for (int i = 0; i < NCLI; i++) begin
                    n = acc_cnt[i];
                    r = rej_cnt[i];
                    mw = mean_q8(wait_sum[i], n);
                    ms = mean_q8(svc_sum[i], n);
                    o = '0;
                    o.index = i[2:0];
                    o.accepted_count = n[15:0];
                    o.rejected_count = r[15:0];
                    o.total_count = n[16:0] + r[16:0];
                    o.mean_wait = mw[31:0];
                    o.mean_service = ms[31:0];
                    o.mean_residence = {1'b0, mw[31:0]} + {1'b0, ms[31:0]};
                    o.var_wait = var_q8(wait_sq[i], n, mw);
                    o.var_service = var_q8(svc_sq[i], n, ms);
                    o.ratio = ((n + r) == 0) ? '0 : ((r << 16) / (n + r));
                    report_q = {report_q, o};
                end
                for (int i = 0; i < NSRV; i++) begin
                    d = last_fin[i];
                    o = '0;
                    o.is_server = 1'b1;
                    o.index = i[2:0];
                    if (d != 0) begin
                        rt = ({64'd0, busy_sum[i]} << 16) / d;
                        o.ratio = (rt > RATIO_ONE) ? RATIO_ONE : rt[16:0];
                    end
                    o.last = (i == NSRV - 1);
                    report_q = {report_q, o};
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predict_report(it);
    endtask

    function automatic t_in_item make_rec(logic [1:0] f, int c, int s,
                                          logic [23:0] te, logic [23:0] ts, logic [23:0] tf);
        t_in_item it;
        it.func = f;
        it.client = c[2:0];
        it.server = s[2:0];
        it.time_enter = te;
        it.time_start = ts;
        it.time_finish = tf;
        return it;
    endfunction

    function automatic t_in_item rand_item();
        logic [1:0] f;
        int sel;
        sel = $urandom_range(99);
        if (sel < 6) f = FUNC_REPORT;
        else if (sel < 9) f = FUNC_NONE;
        else if (sel < 25) f = FUNC_REJECT;
        else f = FUNC_ACCEPT;
        if ($urandom_range(99) < 80) begin
            tick = tick + 24'($urandom_range(4000));
            return make_rec(f, $urandom_range(7), $urandom_range(7), tick,
                            tick + 24'($urandom_range(3000)),
                            tick + 24'(3000 + $urandom_range(5000)));
        end
        return make_rec(f, $urandom_range(7), $urandom_range(7), 24'($urandom),
                        24'($urandom), 24'($urandom));
    endfunction

    // output side: random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (pressure_req) begin
            hold_cnt = 400;
            pressure_req = 1'b0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (report_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected item, expected none, got %h", $time, out_item);
            end else begin
                e = report_q.pop_front();
                check_field("is_server", e.is_server, out_item.is_server);
                check_field("index", e.index, out_item.index);
                check_field("accepted_count", e.accepted_count, out_item.accepted_count);
                check_field("rejected_count", e.rejected_count, out_item.rejected_count);
                check_field("total_count", e.total_count, out_item.total_count);
                check_field("mean_wait", e.mean_wait, out_item.mean_wait);
                check_field("mean_service", e.mean_service, out_item.mean_service);
                check_field("mean_residence", e.mean_residence, out_item.mean_residence);
                check_field("var_wait", e.var_wait, out_item.var_wait);
                check_field("var_service", e.var_service, out_item.var_service);
                check_field("ratio", e.ratio, out_item.ratio);
                check_field("last", e.last, out_item.last);
            end
        end
    end

    task automatic test_empty_report();
        send_item(make_rec(FUNC_REPORT, 0, 0, 0, 0, 0));
    endtask

    task automatic test_directed();
        send_item(make_rec(FUNC_ACCEPT, 0, 0, 24'h0, 24'hFFFFFF, 24'hFFFFFF));
        send_item(make_rec(FUNC_ACCEPT, 0, 7, 24'h0, 24'h0, 24'hFFFFFF));
        send_item(make_rec(FUNC_ACCEPT, 7, 7, 24'hFFFFFF, 24'h0, 24'h0));
        send_item(make_rec(FUNC_ACCEPT, 7, 3, 24'h000100, 24'h000080, 24'h000040));
        send_item(make_rec(FUNC_ACCEPT, 3, 3, 24'h000010, 24'h000020, 24'h000100));
        send_item(make_rec(FUNC_ACCEPT, 3, 3, 24'h000010, 24'h000013, 24'h000017));
        send_item(make_rec(FUNC_REJECT, 3, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_item(make_rec(FUNC_REJECT, 5, 0, 0, 0, 0));
        send_item(make_rec(FUNC_REJECT, 5, 0, 0, 0, 0));
        send_item(make_rec(FUNC_NONE, 1, 1, 24'hAAAAAA, 24'h555555, 24'h123456));
        send_item(make_rec(FUNC_ACCEPT, 1, 5, 24'h000005, 24'h000005, 24'h000005));
        send_item(make_rec(FUNC_ACCEPT, 2, 6, 24'h000001, 24'h000002, 24'h00000A));
        send_item(make_rec(FUNC_REPORT, 7, 7, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    endtask

    task automatic test_pressure();
        idle_pct = 0;
        pressure_req = 1'b1;
        send_item(make_rec(FUNC_REPORT, 0, 0, 0, 0, 0));
        for (int i = 0; i < 4; i++) send_item(rand_item());
        send_item(make_rec(FUNC_REPORT, 0, 0, 0, 0, 0));
        idle_pct = 27;
    endtask

    task automatic test_random();
        for (int i = 0; i < 80; i++) send_item(rand_item());
        send_item(make_rec(FUNC_REPORT, 0, 0, 0, 0, 0));
    endtask

    initial begin
        clear_stats();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_report();
        test_directed();
        test_pressure();
        test_random();
        in_valid <= 1'b0;
        while (report_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && report_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: queue_stats_accumulator.f
src/qsa_pkg.sv
src/qsa_div.sv
src/qsa_datapath.sv
src/qsa_ctrl.sv
src/queue_stats_accumulator.sv
dv/queue_stats_accumulator_test.sv
